[sv/friction_cone_eval_macros.svh]
// Assertion helpers used by the checker.
`ifndef FRICTION_CONE_EVAL_MACROS_SVH
`define FRICTION_CONE_EVAL_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define FCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define FCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/fce_pkg.sv]
package fce_pkg;

  localparam int IDX_W = 8;
  typedef logic [IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FRICTION_COEF = 8'd0;
  localparam cfg_idx_t CFG_TANGENT_REG   = 8'd1;
  localparam cfg_idx_t CFG_GRIP_FORCE    = 8'd2;
  localparam cfg_idx_t CFG_DIAG_SHIFT    = 8'd3;

  localparam logic [30:0] FRICTION_COEF_RST = 31'd45875;
  localparam logic [30:0] TANGENT_REG_RST   = 31'd65536;

  localparam int SQRT_STEPS = 32;  // one root bit per cell
  localparam int FRAC_STEPS = 32;  // n*2^32/S, one quotient bit per cell
  localparam int GRAD_STEPS = 17;  // |x|*2^16/norm, quotient below 2^17
  localparam int HDIV_STEPS = 33;  // q/norm, q up to 2^32

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v > 49'sd2147483647) r = 32'sh7fffffff;
    else if (v < -49'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[sv/fce_in_if.sv]
interface fce_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  modport source(output valid, force_x, force_y, force_z, input ready);
  modport sink(input valid, force_x, force_y, force_z, output ready);
endinterface

[sv/fce_out_if.sv]
interface fce_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] cone_value;
  logic signed [17:0] grad_x;
  logic signed [17:0] grad_y;
  logic signed [31:0] hess_xx;
  logic signed [31:0] hess_xy;
  logic signed [31:0] hess_yy;
  modport source(output valid, cone_value, grad_x, grad_y, hess_xx, hess_xy, hess_yy,
                 input ready);
  modport sink(input valid, cone_value, grad_x, grad_y, hess_xx, hess_xy, hess_yy,
               output ready);
endinterface

[sv/fce_cfg_if.sv]
interface fce_cfg_if;
  logic              valid;
  logic              ready;
  fce_pkg::cfg_idx_t index;
  logic [31:0]       data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[sv/fce_sqrt_cell.sv]
// One digit of a restoring integer square root; BIT selects the radicand pair.
module fce_sqrt_cell #(
  parameter int BIT = 31
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] s_in,
  input  logic [34:0] rem_in,
  input  logic [31:0] root_in,
  output logic [63:0] s_out,
  output logic [34:0] rem_out,
  output logic [31:0] root_out
);
  logic [63:0] s_r;
  logic [34:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [34:0] t, trial;

  always_comb begin
    t     = {rem_in[32:0], s_in[2*BIT+1 -: 2]};
    trial = {1'b0, root_in, 2'b01};
    if (t >= trial) begin
      rem_nxt  = t - trial;
      root_nxt = {root_in[30:0], 1'b1};
    end else begin
      rem_nxt  = t;
      root_nxt = {root_in[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r    <= s_in;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign s_out    = s_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
endmodule

[sv/fce_div_cell.sv]
// One step of restoring division: brings in numerator bit POS, emits one quotient bit.
module fce_div_cell #(
  parameter int RW  = 32,
  parameter int NW  = 48,
  parameter int QW  = 17,
  parameter int POS = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_in,
  input  logic [RW-1:0] rem_in,
  input  logic [RW-1:0] d_in,
  input  logic [QW-1:0] q_in,
  output logic [NW-1:0] n_out,
  output logic [RW-1:0] rem_out,
  output logic [RW-1:0] d_out,
  output logic [QW-1:0] q_out
);
  logic [NW-1:0] n_r;
  logic [RW-1:0] rem_r, rem_nxt, d_r;
  logic [QW-1:0] q_r, q_nxt;
  logic [RW:0]   t, dx, diff;

  always_comb begin
    t    = {rem_in, n_in[POS]};
    dx   = {1'b0, d_in};
    diff = t - dx;
    if (t >= dx) begin
      rem_nxt = diff[RW-1:0];
      q_nxt   = {q_in[QW-2:0], 1'b1};
    end else begin
      rem_nxt = t[RW-1:0];
      q_nxt   = {q_in[QW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_in;
      rem_r <= rem_nxt;
      d_r   <= d_in;
      q_r   <= q_nxt;
    end
  end

  assign n_out   = n_r;
  assign rem_out = rem_r;
  assign d_out   = d_r;
  assign q_out   = q_r;
endmodule

[sv/friction_cone_eval.sv]
// Smoothed friction cone evaluator.
// in_ch  : one contact force (force_x/y/z, Q16.16) per transaction.
// out_ch : cone value, tangential gradient and 2x2 tangential Hessian per force.
// cfg_ch : register writes (index 0 mu, 1 regularizer, 2 grip, 3 diag shift);
//          always ready, unknown indexes are dropped. Write only while idle.
// Throughput: one force per cycle while out_ch is not stalled.
// Pipeline from acceptance to out_ch.valid: products (stage A), sums (stage B),
// 32 square-root cells (one root bit each) beside 32 fraction-divide cells, one
// combine stage, 33 Hessian divide cells by the norm, then the output register.
// The whole pipeline moves together: while out_ch holds a result the receiver has
// not taken, every stage stalls and in_ch.ready drops in the same cycle.
// Reset clears the valid bits of all stages and loads the register defaults
// (mu 0.7, regularizer 1.0, grip 0, shift 0).
module friction_cone_eval (
  input  logic  clk,
  input  logic  rst_n,
  fce_in_if.sink    in_ch,
  fce_out_if.source out_ch,
  fce_cfg_if.sink   cfg_ch
);
  import fce_pkg::*;

  typedef struct packed {
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic               sx;
    logic               sy;
    logic signed [47:0] cone_pre;
    logic               fxx;
    logic               fxy;
    logic               fyy;
  } side_a_t;

  typedef struct packed {
    logic signed [31:0] cone;
    logic               sx;
    logic               sy;
    logic               zero;
  } side_b_t;

  // configuration
  logic [30:0]        mu_r, reg_r, shift_r;
  logic signed [31:0] grip_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_r    <= FRICTION_COEF_RST;
      reg_r   <= TANGENT_REG_RST;
      grip_r  <= '0;
      shift_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FRICTION_COEF: mu_r    <= cfg_ch.data[30:0];
        CFG_TANGENT_REG:   reg_r   <= cfg_ch.data[30:0];
        CFG_GRIP_FORCE:    grip_r  <= cfg_ch.data;
        CFG_DIAG_SHIFT:    shift_r <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic en;
  assign en          = !(out_valid_r && !out_ch.ready);
  assign in_ch.ready = en;

  // stage A: products
  logic [31:0]        ax_c, ay_c;
  logic signed [32:0] zg_c;
  logic signed [64:0] prod_c;
  logic [63:0]        a_x2_r, a_y2_r, a_xy_r;
  logic [31:0]        a_ax_r, a_ay_r;
  logic               a_sx_r, a_sy_r, a_v_r;
  logic signed [63:0] a_prod_r;

  assign ax_c   = in_ch.force_x[31] ? (~in_ch.force_x + 32'd1) : in_ch.force_x;
  assign ay_c   = in_ch.force_y[31] ? (~in_ch.force_y + 32'd1) : in_ch.force_y;
  assign zg_c   = {in_ch.force_z[31], in_ch.force_z} + {grip_r[31], grip_r};
  assign prod_c = $signed({1'b0, mu_r}) * zg_c;

  always_ff @(posedge clk) begin
    if (en) begin
      a_x2_r   <= ax_c * ax_c;
      a_y2_r   <= ay_c * ay_c;
      a_xy_r   <= ax_c * ay_c;
      a_ax_r   <= ax_c;
      a_ay_r   <= ay_c;
      a_sx_r   <= in_ch.force_x[31];
      a_sy_r   <= in_ch.force_y[31];
      a_prod_r <= prod_c[63:0];
    end
  end

  // stage B: sums
  logic [63:0]        regw_c;
  logic [63:0]        b_s_r, b_nxx_r, b_nyy_r, b_nxy_r;
  logic [31:0]        b_ax_r, b_ay_r;
  logic               b_sx_r, b_sy_r, b_v_r;
  logic signed [47:0] b_cone_pre_r;

  assign regw_c = {17'd0, reg_r, 16'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      b_s_r        <= a_x2_r + a_y2_r + regw_c;
      b_nxx_r      <= a_y2_r + regw_c;
      b_nyy_r      <= a_x2_r + regw_c;
      b_nxy_r      <= a_xy_r;
      b_ax_r       <= a_ax_r;
      b_ay_r       <= a_ay_r;
      b_sx_r       <= a_sx_r;
      b_sy_r       <= a_sy_r;
      b_cone_pre_r <= a_prod_r[63:16];
    end
  end

  // square root and fraction chains
  logic [63:0] sq_s    [0:SQRT_STEPS];
  logic [34:0] sq_rem  [0:SQRT_STEPS];
  logic [31:0] sq_root [0:SQRT_STEPS];
  logic [63:0] fr_rem  [0:2][0:FRAC_STEPS];
  logic [63:0] fr_d    [0:2][0:FRAC_STEPS];
  logic [31:0] fr_q    [0:2][0:FRAC_STEPS];
  logic [0:0]  fr_n    [0:2][0:FRAC_STEPS];
  side_a_t     sa      [0:SQRT_STEPS];
  logic        va      [0:SQRT_STEPS];

  assign sq_s[0]    = b_s_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign fr_rem[0][0] = b_nxx_r;
  assign fr_rem[1][0] = b_nxy_r;
  assign fr_rem[2][0] = b_nyy_r;

  genvar g, k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      fce_sqrt_cell #(.BIT(SQRT_STEPS - 1 - k)) u_cell (
        .clk(clk), .en(en),
        .s_in(sq_s[k]), .rem_in(sq_rem[k]), .root_in(sq_root[k]),
        .s_out(sq_s[k+1]), .rem_out(sq_rem[k+1]), .root_out(sq_root[k+1])
      );
    end
    for (g = 0; g < 3; g++) begin : g_frac
      assign fr_d[g][0] = b_s_r;
      assign fr_q[g][0] = '0;
      assign fr_n[g][0] = 1'b0;
      for (k = 0; k < FRAC_STEPS; k++) begin : g_step
        fce_div_cell #(.RW(64), .NW(1), .QW(32), .POS(0)) u_cell (
          .clk(clk), .en(en),
          .n_in(fr_n[g][k]), .rem_in(fr_rem[g][k]), .d_in(fr_d[g][k]), .q_in(fr_q[g][k]),
          .n_out(fr_n[g][k+1]), .rem_out(fr_rem[g][k+1]), .d_out(fr_d[g][k+1]),
          .q_out(fr_q[g][k+1])
        );
      end
    end
  endgenerate

  // numerator at or above S means the fraction is exactly one
  assign sa[0] = '{ax: b_ax_r, ay: b_ay_r, sx: b_sx_r, sy: b_sy_r, cone_pre: b_cone_pre_r,
                   fxx: (b_nxx_r >= b_s_r), fxy: (b_nxy_r >= b_s_r),
                   fyy: (b_nyy_r >= b_s_r)};
  assign va[0] = b_v_r;

  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sa
      always_ff @(posedge clk) begin
        if (en) sa[k+1] <= sa[k];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) va[k+1] <= 1'b0;
        else if (en) va[k+1] <= va[k];
      end
    end
  endgenerate

  // stage C: combine
  logic [31:0]        norm_c;
  logic signed [48:0] cdiff_c;
  logic [31:0]        c_norm_r, c_ax_r, c_ay_r;
  logic [32:0]        c_q_r [0:2];
  side_b_t            c_side_r;
  logic               c_v_r;

  assign norm_c  = sq_root[SQRT_STEPS];
  assign cdiff_c = {sa[SQRT_STEPS].cone_pre[47], sa[SQRT_STEPS].cone_pre}
                   - $signed({17'd0, norm_c});

  always_ff @(posedge clk) begin
    if (en) begin
      c_norm_r <= norm_c;
      c_ax_r   <= sa[SQRT_STEPS].ax;
      c_ay_r   <= sa[SQRT_STEPS].ay;
      c_q_r[0] <= sa[SQRT_STEPS].fxx ? 33'h1_0000_0000 : {1'b0, fr_q[0][FRAC_STEPS]};
      c_q_r[1] <= sa[SQRT_STEPS].fxy ? 33'h1_0000_0000 : {1'b0, fr_q[1][FRAC_STEPS]};
      c_q_r[2] <= sa[SQRT_STEPS].fyy ? 33'h1_0000_0000 : {1'b0, fr_q[2][FRAC_STEPS]};
      c_side_r <= '{cone: sat32(cdiff_c), sx: sa[SQRT_STEPS].sx, sy: sa[SQRT_STEPS].sy,
                    zero: (norm_c == 32'd0)};
    end
  end

  // divides by the norm
  logic [47:0] gd_n   [0:1][0:GRAD_STEPS];
  logic [31:0] gd_rem [0:1][0:GRAD_STEPS];
  logic [31:0] gd_d   [0:1][0:GRAD_STEPS];
  logic [16:0] gd_q   [0:1][0:GRAD_STEPS];
  logic [32:0] hd_n   [0:2][0:HDIV_STEPS];
  logic [31:0] hd_rem [0:2][0:HDIV_STEPS];
  logic [31:0] hd_d   [0:2][0:HDIV_STEPS];
  logic [32:0] hd_q   [0:2][0:HDIV_STEPS];

  assign gd_n[0][0]   = {c_ax_r, 16'd0};
  assign gd_n[1][0]   = {c_ay_r, 16'd0};
  assign gd_rem[0][0] = {1'b0, c_ax_r[31:1]};
  assign gd_rem[1][0] = {1'b0, c_ay_r[31:1]};

  generate
    for (g = 0; g < 2; g++) begin : g_grad
      assign gd_d[g][0] = c_norm_r;
      assign gd_q[g][0] = '0;
      for (k = 0; k < GRAD_STEPS; k++) begin : g_step
        fce_div_cell #(.RW(32), .NW(48), .QW(17), .POS(GRAD_STEPS - 1 - k)) u_cell (
          .clk(clk), .en(en),
          .n_in(gd_n[g][k]), .rem_in(gd_rem[g][k]), .d_in(gd_d[g][k]), .q_in(gd_q[g][k]),
          .n_out(gd_n[g][k+1]), .rem_out(gd_rem[g][k+1]), .d_out(gd_d[g][k+1]),
          .q_out(gd_q[g][k+1])
        );
      end
    end
    for (g = 0; g < 3; g++) begin : g_hdiv
      assign hd_n[g][0]   = c_q_r[g];
      assign hd_rem[g][0] = '0;
      assign hd_d[g][0]   = c_norm_r;
      assign hd_q[g][0]   = '0;
      for (k = 0; k < HDIV_STEPS; k++) begin : g_step
        fce_div_cell #(.RW(32), .NW(33), .QW(33), .POS(HDIV_STEPS - 1 - k)) u_cell (
          .clk(clk), .en(en),
          .n_in(hd_n[g][k]), .rem_in(hd_rem[g][k]), .d_in(hd_d[g][k]), .q_in(hd_q[g][k]),
          .n_out(hd_n[g][k+1]), .rem_out(hd_rem[g][k+1]), .d_out(hd_d[g][k+1]),
          .q_out(hd_q[g][k+1])
        );
      end
    end
  endgenerate

  // gradients finish early; hold them until the Hessian divides catch up
  localparam int GDLY = HDIV_STEPS - GRAD_STEPS;
  logic [16:0] gdl [0:1][0:GDLY];
  side_b_t     sb  [0:HDIV_STEPS];
  logic        vb  [0:HDIV_STEPS];

  assign gdl[0][0] = gd_q[0][GRAD_STEPS];
  assign gdl[1][0] = gd_q[1][GRAD_STEPS];
  assign sb[0]     = c_side_r;
  assign vb[0]     = c_v_r;

  generate
    for (k = 0; k < GDLY; k++) begin : g_gdl
      always_ff @(posedge clk) begin
        if (en) begin
          gdl[0][k+1] <= gdl[0][k];
          gdl[1][k+1] <= gdl[1][k];
        end
      end
    end
    for (k = 0; k < HDIV_STEPS; k++) begin : g_sb
      always_ff @(posedge clk) begin
        if (en) sb[k+1] <= sb[k];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) vb[k+1] <= 1'b0;
        else if (en) vb[k+1] <= vb[k];
      end
    end
  endgenerate

  // valid bits of the head and combine stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_ch.valid;
      b_v_r <= a_v_r;
      c_v_r <= va[SQRT_STEPS];
    end
  end

  // output stage
  side_b_t            se;
  logic [32:0]        mxx_c, mxy_c, myy_c;
  logic [16:0]        mgx_c, mgy_c;
  logic signed [35:0] hxx_c, hxy_c, hyy_c;
  logic signed [17:0] gx_c, gy_c;

  always_comb begin
    se    = sb[HDIV_STEPS];
    mxx_c = se.zero ? 33'd0 : hd_q[0][HDIV_STEPS];
    mxy_c = se.zero ? 33'd0 : hd_q[1][HDIV_STEPS];
    myy_c = se.zero ? 33'd0 : hd_q[2][HDIV_STEPS];
    mgx_c = se.zero ? 17'd0 : gdl[0][GDLY];
    mgy_c = se.zero ? 17'd0 : gdl[1][GDLY];
    hxx_c = -$signed({3'd0, mxx_c}) - $signed({5'd0, shift_r});
    hyy_c = -$signed({3'd0, myy_c}) - $signed({5'd0, shift_r});
    hxy_c = (se.sx ^ se.sy) ? -$signed({3'd0, mxy_c}) : $signed({3'd0, mxy_c});
    gx_c  = se.sx ? $signed({1'b0, mgx_c}) : -$signed({1'b0, mgx_c});
    gy_c  = se.sy ? $signed({1'b0, mgy_c}) : -$signed({1'b0, mgy_c});
  end

  logic signed [31:0] out_cone_r, out_hxx_r, out_hxy_r, out_hyy_r;
  logic signed [17:0] out_gx_r, out_gy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vb[HDIV_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cone_r <= se.cone;
      out_gx_r   <= gx_c;
      out_gy_r   <= gy_c;
      out_hxx_r  <= sat32({{13{hxx_c[35]}}, hxx_c});
      out_hxy_r  <= sat32({{13{hxy_c[35]}}, hxy_c});
      out_hyy_r  <= sat32({{13{hyy_c[35]}}, hyy_c});
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cone_value = out_cone_r;
  assign out_ch.grad_x     = out_gx_r;
  assign out_ch.grad_y     = out_gy_r;
  assign out_ch.hess_xx    = out_hxx_r;
  assign out_ch.hess_xy    = out_hxy_r;
  assign out_ch.hess_yy    = out_hyy_r;
endmodule

[sv/fce_checker.sv]
`include "friction_cone_eval_macros.svh"

module fce_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] cone_value,
  input logic signed [17:0] grad_x,
  input logic signed [17:0] grad_y
);
  // a held result keeps its cone value
  `FCE_ASSERT(a_out_hold,
              out_valid && !out_ready |=> out_valid && $stable(cone_value),
              "stalled result changed")
  // input side only stalls behind an untaken result
  `FCE_ASSERT(a_in_ready, !out_valid |-> in_ready, "input stalled with empty output")
  `FCE_ASSERT(a_grad_rng,
              out_valid |-> (grad_x <= 18'sd65536) && (grad_x >= -18'sd65536) &&
                            (grad_y <= 18'sd65536) && (grad_y >= -18'sd65536),
              "gradient out of range")
  `FCE_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_valid, "result valid after reset")
endmodule

bind friction_cone_eval fce_checker u_fce_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .cone_value(out_ch.cone_value),
  .grad_x(out_ch.grad_x),
  .grad_y(out_ch.grad_y)
);

[sim/fce_tb_if.sv]
`timescale 1ns / 100ps
// Interfaces are defined with the RTL; this file holds the result record the bench keeps.
package fce_tb_pkg;
  typedef struct packed {
    logic signed [31:0] cone_value;
    logic signed [17:0] grad_x;
    logic signed [17:0] grad_y;
    logic signed [31:0] hess_xx;
    logic signed [31:0] hess_xy;
    logic signed [31:0] hess_yy;
  } cone_result_t;
endpackage

[sim/tb.sv]
`timescale 1ns / 100ps
module tb;
  import fce_pkg::*;
  import fce_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  fce_in_if  in_ch();
  fce_out_if out_ch();
  fce_cfg_if cfg_ch();

  friction_cone_eval uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                          .cfg_ch(cfg_ch));

  localparam int PIPE_DEPTH = 69;
  localparam cfg_idx_t CFG_UNMAPPED = 8'd7;

  logic [30:0]        mu_reg;
  logic [30:0]        reg_reg;
  logic signed [31:0] grip_reg;
  logic [30:0]        shift_reg;

  cone_result_t expected_q[$];
  int  mismatches = 0;
  bit  hold_off = 0;
  int  burst_left = 0;

  function automatic logic [63:0] isqrt(input logic [63:0] s);
    logic [63:0] r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  // floor(n * 2^32 / d), capped at 2^32
  function automatic logic [63:0] frac_div(input logic [63:0] n, input logic [63:0] d);
    logic [127:0] num;
    if (n >= d) return 64'd1 << 32;
    num = {64'd0, n} << 32;
    return 64'(num / d);
  endfunction

  function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic cone_result_t predict_cone(input logic signed [31:0] x,
      input logic signed [31:0] y, input logic signed [31:0] z);
    cone_result_t r;
    logic [63:0] ax, ay, x2, y2, regw, s, nrm, mx, my;
    logic signed [95:0] prod;
    logic signed [65:0] cone, gx, gy, hxx, hxy, hyy;
    ax = (x < 0) ? 64'(-64'(x)) : 64'(x);
    ay = (y < 0) ? 64'(-64'(y)) : 64'(y);
    x2 = ax * ax;
    y2 = ay * ay;
    regw = 64'(reg_reg) << 16;
    s = x2 + y2 + regw;
    nrm = isqrt(s);
    prod = $signed({1'b0, mu_reg}) * (96'(z) + 96'(grip_reg));
    cone = 66'(prod >>> 16) - $signed({2'b0, nrm});
    gx = 0; gy = 0; hxy = 0;
    hxx = -$signed(66'(shift_reg));
    hyy = hxx;
    if (nrm != 0) begin
      mx = (ax << 16) / nrm;
      my = (ay << 16) / nrm;
      gx = (x < 0) ? $signed({2'b0, mx}) : -$signed({2'b0, mx});
      gy = (y < 0) ? $signed({2'b0, my}) : -$signed({2'b0, my});
      hxy = $signed({2'b0, frac_div(ax * ay, s) / nrm});
      if ((x < 0) != (y < 0)) hxy = -hxy;
      hxx = -$signed({2'b0, frac_div(y2 + regw, s) / nrm}) - $signed(66'(shift_reg));
      hyy = -$signed({2'b0, frac_div(x2 + regw, s) / nrm}) - $signed(66'(shift_reg));
    end
    if (gx > 65536) gx = 65536;
    if (gx < -65536) gx = -65536;
    if (gy > 65536) gy = 65536;
    if (gy < -65536) gy = -65536;
    r.cone_value = sat66(cone);
    r.grad_x = gx[17:0];
    r.grad_y = gy[17:0];
    r.hess_xx = sat66(hxx);
    r.hess_xy = sat66(hxy);
    r.hess_yy = sat66(hyy);
    return r;
  endfunction

  // Sender transfers come in bursts separated by gaps; valid stays high across a burst.
  task automatic send_force(input logic signed [31:0] x, input logic signed [31:0] y,
                            input logic signed [31:0] z, input bit gaps);
    int gap;
    if (gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
    end
    in_ch.valid <= 1'b1;
    in_ch.force_x <= x;
    in_ch.force_y <= y;
    in_ch.force_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_cone(x, y, z));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 5) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_FRICTION_COEF: mu_reg = data[30:0];
      CFG_TANGENT_REG:   reg_reg = data[30:0];
      CFG_GRIP_FORCE:    grip_reg = data;
      CFG_DIAG_SHIFT:    shift_reg = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_force();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 131072)) - 65536);
      2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      3: return {1'b0, 31'h7fffffff} - $urandom_range(0, 3);
      4: return 32'h80000000 + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 40000000)) - 20000000);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] ext[5];
    ext = '{32'sh80000000, 32'sh7fffffff, 0, -32'sd1, 32'sd65536};
    for (int i = 0; i < 5; i++)
      send_force(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5], 0);
    send_force(0, 0, 0, 0);
    send_force(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_force(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_force(-32'sd65536, 32'sd65536, 32'sd131072, 0);
    send_force(32'sd3, -32'sd5, -32'sd7, 0);
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_FRICTION_COEF, 32'hffffffff);
    write_reg(CFG_TANGENT_REG, 32'h7fffffff);
    write_reg(CFG_GRIP_FORCE, 32'h7fffffff);
    write_reg(CFG_DIAG_SHIFT, 32'h7fffffff);
    write_reg(CFG_UNMAPPED, 32'h12345678);  // dropped index
    for (int i = 0; i < 8; i++) send_force(rand_force(), rand_force(), rand_force(), 0);
    send_force(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 0);
    drain();
    write_reg(CFG_FRICTION_COEF, 0);
    write_reg(CFG_TANGENT_REG, 1);
    write_reg(CFG_GRIP_FORCE, 32'h80000000);
    write_reg(CFG_DIAG_SHIFT, 0);
    send_force(0, 0, 0, 0);
    send_force(1, -1, 32'sh80000000, 0);
    for (int i = 0; i < 6; i++) send_force(rand_force(), rand_force(), rand_force(), 0);
    drain();
  endtask

  task automatic test_random_phase(input int count);
    write_reg(CFG_FRICTION_COEF, $urandom_range(0, 3) == 0 ? $urandom() :
              $urandom_range(0, 131072));
    write_reg(CFG_TANGENT_REG, $urandom_range(0, 3) == 0 ? $urandom() | 1 :
              $urandom_range(1, 200000));
    write_reg(CFG_GRIP_FORCE, $urandom_range(0, 1) ? $urandom() :
              32'($signed($urandom_range(0, 200000)) - 100000));
    write_reg(CFG_DIAG_SHIFT, $urandom_range(0, 3) == 0 ? $urandom() :
              $urandom_range(0, 70000));
    for (int i = 0; i < count; i++) send_force(rand_force(), rand_force(), rand_force(), 1);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    for (int i = 0; i < 120; i++) send_force(rand_force(), rand_force(), rand_force(), 0);
    drain();
  endtask

  // Receiver: stall pattern plus a long hold-off window.
  int stall_phase = 0;
  int hold_cycles = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
      hold_cycles++;
      if (hold_cycles >= 300) begin
        hold_off = 0;
        hold_cycles = 0;
      end
    end else begin
      stall_phase = (stall_phase + 1) % 400;
      if (stall_phase < 150) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 99) < 65);
    end
  end

  always @(posedge clk) begin
    cone_result_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.cone_value, out_ch.grad_x, out_ch.grad_y, out_ch.hess_xx,
              out_ch.hess_xy, out_ch.hess_yy};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.force_x = 0;
    in_ch.force_y = 0;
    in_ch.force_z = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_FRICTION_COEF;
    cfg_ch.data = 0;
    out_ch.ready = 1'b0;
    mu_reg = FRICTION_COEF_RST;
    reg_reg = TANGENT_REG_RST;
    grip_reg = 0;
    shift_reg = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_register_extremes();
    test_backpressure();
    for (int p = 0; p < 8; p++) test_random_phase(200);
    if (expected_q.size() != 0) mismatches++;
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

[friction_cone_eval.f]
+incdir+sv
sv/fce_pkg.sv
sv/fce_in_if.sv
sv/fce_out_if.sv
sv/fce_cfg_if.sv
sv/fce_sqrt_cell.sv
sv/fce_div_cell.sv
sv/friction_cone_eval.sv
sv/fce_checker.sv
sim/fce_tb_if.sv
sim/tb.sv
